// ===== hdl/lr_pkg.sv =====
`default_nettype none

package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int WIDTH_BITS = 13;
  localparam int ADDR_BITS = 24;
  localparam int MAC_BITS = (COORD_BITS + WIDTH_BITS + 1 > ADDR_BITS) ?
                            (COORD_BITS + WIDTH_BITS + 1) : ADDR_BITS;

  localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(1024);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } lr_request_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic                  last_pixel;
  } lr_result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } lr_pixel_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } lr_queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/lr_front.sv =====
`default_nettype none

module lr_front import lr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             request_valid,
  output logic                  request_stall,
  input  wire lr_request_t      request,
  input  wire lr_queue_status_t queue_status,
  output logic                  push,
  output lr_pixel_t             push_pixel
);

  logic [COORD_BITS-1:0] cur_x, cur_y, target_x, target_y;
  logic [COORD_BITS-1:0] cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic signed [DELTA_BITS-1:0] delta_x, neg_delta_y;
  logic signed [DELTA_BITS-1:0] delta_x_next, neg_delta_y_next;
  logic step_x_neg, step_y_neg, step_x_neg_next, step_y_neg_next;
  logic signed [ERR_BITS-1:0] error_term, error_term_next;
  logic line_active, line_active_next;

  logic accept, is_start;
  logic [COORD_BITS-1:0] abs_dx, abs_dy, adv_x, adv_y;
  logic signed [ERR_BITS:0] twice, ndy_ext, dx_ext;
  logic signed [ERR_BITS-1:0] err_add_x, err_add_y;
  logic cond_x, cond_y, guard;

  assign request_stall = queue_status.full;
  assign accept = request_valid && !request_stall;
  assign is_start = (request.mode == MODE_START);

  always_comb begin
    abs_dx = (request.end_x >= request.start_x) ? (request.end_x - request.start_x)
                                                : (request.start_x - request.end_x);
    abs_dy = (request.end_y >= request.start_y) ? (request.end_y - request.start_y)
                                                : (request.start_y - request.end_y);
    twice = {error_term, 1'b0};
    ndy_ext = {{(ERR_BITS + 1 - DELTA_BITS){neg_delta_y[DELTA_BITS-1]}}, neg_delta_y};
    dx_ext = {{(ERR_BITS + 1 - DELTA_BITS){delta_x[DELTA_BITS-1]}}, delta_x};
    cond_x = (twice >= ndy_ext);
    cond_y = (twice <= dx_ext);
    guard = (cond_x && (cur_x == target_x)) || (cond_y && (cur_y == target_y));
    err_add_x = cond_x ? ndy_ext[ERR_BITS-1:0] : '0;
    err_add_y = cond_y ? dx_ext[ERR_BITS-1:0] : '0;
    adv_x = cond_x ? (step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
    adv_y = cond_y ? (step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;

    cur_x_next = cur_x;
    cur_y_next = cur_y;
    target_x_next = target_x;
    target_y_next = target_y;
    delta_x_next = delta_x;
    neg_delta_y_next = neg_delta_y;
    step_x_neg_next = step_x_neg;
    step_y_neg_next = step_y_neg;
    error_term_next = error_term;
    line_active_next = line_active;
    push = 1'b0;

    if (accept && is_start) begin
      cur_x_next = request.start_x;
      cur_y_next = request.start_y;
      target_x_next = request.end_x;
      target_y_next = request.end_y;
      step_x_neg_next = !(request.start_x < request.end_x);
      step_y_neg_next = !(request.start_y < request.end_y);
      delta_x_next = {1'b0, abs_dx};
      neg_delta_y_next = -$signed({1'b0, abs_dy});
      error_term_next = ERR_BITS'($signed({1'b0, abs_dx})) -
                        ERR_BITS'($signed({1'b0, abs_dy}));
      push = 1'b1;
    end else if (accept && line_active) begin
      if (guard) begin
        line_active_next = 1'b0;
      end else begin
        cur_x_next = adv_x;
        cur_y_next = adv_y;
        error_term_next = error_term + err_add_x + err_add_y;
        push = 1'b1;
      end
    end

    push_pixel.x = cur_x_next;
    push_pixel.y = cur_y_next;
    push_pixel.last = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);
    if (push) begin
      line_active_next = !push_pixel.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      target_x <= '0;
      target_y <= '0;
      delta_x <= '0;
      neg_delta_y <= '0;
      step_x_neg <= 1'b0;
      step_y_neg <= 1'b0;
      error_term <= '0;
      line_active <= 1'b0;
    end else begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
      target_x <= target_x_next;
      target_y <= target_y_next;
      delta_x <= delta_x_next;
      neg_delta_y <= neg_delta_y_next;
      step_x_neg <= step_x_neg_next;
      step_y_neg <= step_y_neg_next;
      error_term <= error_term_next;
      line_active <= line_active_next;
    end
  end

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept) else $error("push without accepted request");

  a_start_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && is_start) |-> push) else $error("start request gave no pixel");

  a_idle_advance_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_start && !line_active) |-> !push)
    else $error("advance with no line gave a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (push && push_pixel.last) |=> !line_active)
    else $error("line still active after endpoint");

endmodule

`default_nettype wire

// ===== hdl/lr_queue.sv =====
`default_nettype none

module lr_queue import lr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire lr_pixel_t  push_pixel,
  input  wire logic       pop,
  output lr_pixel_t       head,
  output lr_queue_status_t status
);

  lr_pixel_t entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0] count;

  assign status.not_empty = (count != '0);
  assign status.full = (count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lr_back.sv =====
`default_nettype none

module lr_back import lr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_enable,
  input  wire logic [WIDTH_BITS-1:0] cfg_write_data,
  input  wire lr_queue_status_t      queue_status,
  input  wire lr_pixel_t             head,
  output logic                       pop,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output lr_result_t                 result
);

  logic [WIDTH_BITS-1:0] frame_width;
  logic [MAC_BITS-1:0] mac;

  assign pop = queue_status.not_empty && (!result_valid || !result_stall);
  assign mac = MAC_BITS'(head.y) * MAC_BITS'(frame_width) + MAC_BITS'(head.x);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
    end else if (cfg_write_enable) begin
      frame_width <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.pixel_x <= head.x;
      result.pixel_y <= head.y;
      result.pixel_address <= mac[ADDR_BITS-1:0];
      result.last_pixel <= head.last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/line_rasterizer_core.sv =====
// channel   | handshake                      | payload
// request   | request_valid / request_stall  | request (lr_request_t)
// result    | result_valid / result_stall    | result (lr_result_t)
// config    | cfg_write_enable               | cfg_write_data (frame_width)
//
// One request per cycle while request_stall is low; a pixel is held in a queue entry,
// then in the result register. Stepper state update and queue push share one cycle;
// the address multiply-add sits before the result register.
// rst is synchronous: no line active, frame_width 1024, queue and result empty.
// request_stall rises only when the four-entry pixel queue is full.
`default_nettype none

module line_rasterizer_core import lr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  request_valid,
  output logic                       request_stall,
  input  wire lr_request_t           request,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output lr_result_t                 result,
  input  wire logic                  cfg_write_enable,
  input  wire logic [WIDTH_BITS-1:0] cfg_write_data
);

  lr_queue_status_t queue_status;
  lr_pixel_t push_pixel, head;
  logic push, pop;

  lr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .queue_status (queue_status),
    .push         (push),
    .push_pixel   (push_pixel)
  );

  lr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pixel(push_pixel),
    .pop       (pop),
    .head      (head),
    .status    (queue_status)
  );

  lr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .queue_status    (queue_status),
    .head            (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

endmodule

`default_nettype wire

// ===== test/line_rasterizer_checker.sv =====
`default_nettype none

module line_rasterizer_checker import lr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  request_valid,
  input  wire logic                  request_stall,
  input  wire lr_request_t           request,
  input  wire logic                  result_valid,
  input  wire logic                  result_stall,
  input  wire lr_result_t            result,
  input  wire logic                  cfg_write_enable,
  input  wire logic [WIDTH_BITS-1:0] cfg_write_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COORD_BITS-1:0]        cur_x, cur_y, goal_x, goal_y;
  logic signed [DELTA_BITS-1:0] run_x, rise_neg;
  logic signed [ERR_BITS-1:0]   bias;
  logic                         x_down, y_down, drawing;
  logic [WIDTH_BITS-1:0]        row_pitch;
  lr_result_t                   expected_pixels[$];
  int                           errors = 0;
  int                           pending = 0;
  int                           checked = 0;

  assign fail_count    = errors;
  assign pending_count = pending;
  assign checked_count = checked;

  task automatic plot_pixel();
    lr_result_t           pix;
    logic [MAC_BITS-1:0]  addr;
    addr = MAC_BITS'(cur_y) * MAC_BITS'(row_pitch) + MAC_BITS'(cur_x);
    pix.pixel_x       = cur_x;
    pix.pixel_y       = cur_y;
    pix.pixel_address = addr[ADDR_BITS-1:0];
    pix.last_pixel    = (cur_x == goal_x) && (cur_y == goal_y);
    drawing = !pix.last_pixel;
    expected_pixels.push_back(pix);
  endtask

  task automatic trace_line(input lr_request_t req);
    int twice, run_i, rise_i;
    if (req.mode == MODE_START) begin
      cur_x  = req.start_x;
      cur_y  = req.start_y;
      goal_x = req.end_x;
      goal_y = req.end_y;
      x_down = !(req.start_x < req.end_x);
      y_down = !(req.start_y < req.end_y);
      run_x = (req.end_x >= req.start_x) ?
              DELTA_BITS'(req.end_x) - DELTA_BITS'(req.start_x) :
              DELTA_BITS'(req.start_x) - DELTA_BITS'(req.end_x);
      rise_neg = (req.end_y >= req.start_y) ?
                 DELTA_BITS'(req.start_y) - DELTA_BITS'(req.end_y) :
                 DELTA_BITS'(req.end_y) - DELTA_BITS'(req.start_y);
      bias = ERR_BITS'(run_x) + ERR_BITS'(rise_neg);
      plot_pixel();
    end else if (drawing) begin
      twice  = 2 * int'(bias);
      run_i  = int'(run_x);
      rise_i = int'(rise_neg);
      if (twice >= rise_i) begin
        if (cur_x == goal_x) begin
          drawing = 1'b0;
          return;
        end
        bias  = bias + ERR_BITS'(rise_neg);
        cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (twice <= run_i) begin
        if (cur_y == goal_y) begin
          drawing = 1'b0;
          return;
        end
        bias  = bias + ERR_BITS'(run_x);
        cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      plot_pixel();
    end
  endtask

  task automatic compare_pixel(input lr_result_t got);
    lr_result_t want;
    if (expected_pixels.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%t: unexpected pixel x=%0d y=%0d addr=%h last=%b", $realtime,
                 got.pixel_x, got.pixel_y, got.pixel_address, got.last_pixel);
      end
    end else begin
      want = expected_pixels.pop_front();
      checked++;
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pixel_address !== want.pixel_address ||
          got.last_pixel !== want.last_pixel) begin
        errors++;
        if (errors <= 10) begin
          $display("%t: pixel mismatch: expected x=%0d y=%0d addr=%h last=%b", $realtime,
                   want.pixel_x, want.pixel_y, want.pixel_address, want.last_pixel);
          $display("%t:                 actual   x=%0d y=%0d addr=%h last=%b", $realtime,
                   got.pixel_x, got.pixel_y, got.pixel_address, got.last_pixel);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_x     = '0;
      cur_y     = '0;
      goal_x    = '0;
      goal_y    = '0;
      run_x     = '0;
      rise_neg  = '0;
      bias      = '0;
      x_down    = 1'b0;
      y_down    = 1'b0;
      drawing   = 1'b0;
      row_pitch = FRAME_WIDTH_RESET;
      expected_pixels.delete();
    end else begin
      if (result_valid && !result_stall) begin
        compare_pixel(result);
      end
      if (request_valid && !request_stall) begin
        trace_line(request);
      end
      if (cfg_write_enable) begin
        row_pitch = cfg_write_data;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

`default_nettype wire

// ===== test/line_rasterizer_core_tb.sv =====
`default_nettype none

module line_rasterizer_core_tb;
  import lr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASES        = 6;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  request_valid = 1'b0;
  logic                  request_stall;
  lr_request_t           request = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  lr_result_t            result;
  logic                  cfg_write_enable = 1'b0;
  logic [WIDTH_BITS-1:0] cfg_write_data = '0;

  int fail_count, pending_count, checked_count;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_count = 0;
  int sent_count = 0;
  int line_count = 0;
  int width_count = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_rasterizer_core u_top (
    .clk              (clk),
    .rst              (rst),
    .request_valid    (request_valid),
    .request_stall    (request_stall),
    .request          (request),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  line_rasterizer_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .request_valid    (request_valid),
    .request_stall    (request_stall),
    .request          (request),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count)
  );

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((request_valid && !request_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // pixel sink: random back-pressure, one long hold-off on demand
  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
      if (hold_request) begin
        wait_cycles += HOLD_CYCLES;
        hold_request = 1'b0;
        hold_count++;
      end
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  function automatic lr_request_t random_request(input logic mode);
    lr_request_t req;
    req.mode    = mode;
    req.start_x = COORD_BITS'($urandom_range(0, 4095));
    req.start_y = COORD_BITS'($urandom_range(0, 4095));
    req.end_x   = COORD_BITS'($urandom_range(0, 4095));
    req.end_y   = COORD_BITS'($urandom_range(0, 4095));
    return req;
  endfunction

  function automatic int near_coord(input int c, input int span);
    int d, t;
    d = int'($urandom_range(0, 2 * span)) - span;
    t = c + d;
    if (t < 0 || t > 4095) t = c - d;
    return t;
  endfunction

  task automatic send_request(input lr_request_t req);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request       <= req;
    request_valid <= 1'b1;
    do @(posedge clk); while (request_stall);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                           input int advances);
    lr_request_t req;
    req         = random_request(MODE_START);
    req.start_x = COORD_BITS'(x0);
    req.start_y = COORD_BITS'(y0);
    req.end_x   = COORD_BITS'(x1);
    req.end_y   = COORD_BITS'(y1);
    send_request(req);
    repeat (advances) send_request(random_request(MODE_ADVANCE));
  endtask

  // hold the sender until every pixel is out and the stepper is quiet
  task automatic settle_pipeline();
    request_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame_width(input logic [WIDTH_BITS-1:0] pitch);
    settle_pipeline();
    cfg_write_data   <= pitch;
    cfg_write_enable <= 1'b1;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    width_count++;
  endtask

  task automatic random_line();
    int x0, y0, x1, y1, span, dx, dy, steps, n, pick;
    x0   = $urandom_range(0, 4095);
    y0   = $urandom_range(0, 4095);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      x1 = $urandom_range(0, 4095);
      y1 = $urandom_range(0, 4095);
      n  = $urandom_range(0, 20);
    end else begin
      span  = (pick < 8) ? 300 : 12;
      x1    = near_coord(x0, span);
      y1    = near_coord(y0, span);
      dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
      steps = (dx > dy) ? dx : dy;
      if (pick < 15) begin
        n = $urandom_range(0, steps);
      end else if (pick < 22) begin
        n = steps + $urandom_range(1, 3);
      end else begin
        n = steps;
      end
    end
    send_line(x0, y0, x1, y1, n);
    line_count++;
  endtask

  initial begin
    logic [WIDTH_BITS-1:0] pitch;
    int                    phase_end;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // advance with no line, single-pixel line, abandoned corner-to-corner lines, advances past line ends
    send_request(random_request(MODE_ADVANCE));
    send_line(0, 0, 0, 0, 1);
    send_line(0, 0, 4095, 4095, 2);
    send_line(4095, 0, 0, 4095, 2);
    send_line(4095, 4095, 4094, 4092, 4);
    send_line(2, 7, 0, 7, 3);
    send_line(3, 0, 3, 2, 3);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: pitch = WIDTH_BITS'(1);
        1: pitch = WIDTH_BITS'(4096);
        2: pitch = WIDTH_BITS'(0);
        3: pitch = WIDTH_BITS'(8191);
        4: pitch = WIDTH_BITS'($urandom_range(2, 4095));
        default: pitch = FRAME_WIDTH_RESET;
      endcase
      set_frame_width(pitch);
      idle_on = (ph != 3);
      if (ph == 2) begin
        hold_request = 1'b1;
        send_line(100, 200, 160, 230, 60);
      end
      phase_end = sent_count + RANDOM_ITEMS / PHASES;
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(random_request(logic'($urandom_range(0, 1))));
        end else if ($urandom_range(0, 29) == 0) begin
          settle_pipeline();
        end else begin
          random_line();
        end
      end
    end
    idle_on = 1'b1;
    settle_pipeline();

    $display("Sent %0d requests (%0d random lines) across %0d frame widths", sent_count,
             line_count, width_count);
    $display("Checked %0d pixels; long sink hold-offs: %0d; mismatches: %0d", checked_count,
             hold_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/lr_pkg.sv
hdl/lr_front.sv
hdl/lr_queue.sv
hdl/lr_back.sv
hdl/line_rasterizer_core.sv
test/line_rasterizer_checker.sv
test/line_rasterizer_core_tb.sv
